/* rtl/core/mtc_pkg.sv */
// Package for the marching-triangles contour cell.
// Holds the cell and segment beat types and the register map; no dependencies.
package mtc_pkg;

	localparam int ADDR_BITS = 3;
	localparam int REG_IDX_BITS = 1;
	localparam logic [REG_IDX_BITS-1:0] REG_LEVEL = 1'b0;
	localparam logic [REG_IDX_BITS-1:0] REG_UNDEF = 1'b1;

	localparam logic [2:0] PAT_C0 = 3'h4;
	localparam logic [2:0] PAT_C1 = 3'h2;
	localparam logic [2:0] PAT_C2 = 3'h1;

	typedef struct packed {
		logic signed [15:0] axis_a_low;
		logic signed [15:0] axis_a_high;
		logic signed [15:0] axis_b_low;
		logic signed [15:0] axis_b_high;
		logic signed [31:0] value_00;
		logic signed [31:0] value_01;
		logic signed [31:0] value_11;
		logic signed [31:0] value_10;
	} cell_t;

	typedef struct packed {
		logic signed [15:0] start_a;
		logic signed [15:0] start_b;
		logic signed [15:0] end_a;
		logic signed [15:0] end_b;
		logic               triangle_sel;
		logic               last_segment;
	} seg_t;

endpackage

/* rtl/core/mtc_interp.sv */
// Pipelined edge interpolator: c0 + (c1 - c0) * num / den, ratio clipped to [0, 1].
// One multiply stage, then a restoring divider retiring one quotient bit per stage.
module mtc_interp import mtc_pkg::*; #(
	parameter int CW = 16,
	parameter int VW = 32
) (
	input  logic                clk,
	input  logic signed [CW-1:0] c0,
	input  logic signed [CW-1:0] c1,
	input  logic signed [VW:0]   num,
	input  logic signed [VW:0]   den,
	output logic signed [CW-1:0] pt
);

	localparam int PW = CW + VW + 1;

	logic              skip;
	logic [VW:0]       an;
	logic [VW:0]       ad;
	logic signed [CW:0] dc;
	logic [CW:0]       adc;

	logic              skip_s1;
	logic              dneg_s1;
	logic [CW-1:0]     c0_s1;
	logic [CW-1:0]     mdc_s1;
	logic [VW:0]       un_s1;
	logic [VW:0]       ud_s1;
	logic [PW-1:0]     prod;

	logic [VW:0]       rem_d  [0:CW];
	logic [CW-1:0]     lo_d   [0:CW];
	logic [CW-1:0]     quo_d  [0:CW];
	logic [VW:0]       ud_d   [0:CW];
	logic [CW-1:0]     c0_d   [0:CW];
	logic              skip_d [0:CW];
	logic              dneg_d [0:CW];

	logic signed [CW+1:0] sum;
	logic signed [CW+1:0] cmax;
	logic signed [CW+1:0] cmin;
	logic [CW-1:0]        pt_q;

	always_comb begin
		skip = (den == '0) || (num == '0) || (num[VW] != den[VW]);
		an = num[VW] ? (VW+1)'(-num) : (VW+1)'(num);
		ad = den[VW] ? (VW+1)'(-den) : (VW+1)'(den);
		dc = (CW+1)'(c1) - (CW+1)'(c0);
		adc = dc[CW] ? (CW+1)'(-dc) : (CW+1)'(dc);
	end

	always_ff @(posedge clk) begin
		skip_s1 <= skip;
		dneg_s1 <= dc[CW];
		c0_s1 <= c0;
		mdc_s1 <= adc[CW-1:0];
		un_s1 <= (an > ad) ? ad : an;
		ud_s1 <= ad;
	end

	assign prod = PW'(mdc_s1) * PW'(un_s1);

	always_ff @(posedge clk) begin
		rem_d[0] <= prod[PW-1:CW];
		lo_d[0] <= prod[CW-1:0];
		quo_d[0] <= '0;
		ud_d[0] <= ud_s1;
		c0_d[0] <= c0_s1;
		skip_d[0] <= skip_s1;
		dneg_d[0] <= dneg_s1;
	end

	// One quotient bit per stage; the partial remainder always stays below the divisor.
	for (genvar k = 0; k < CW; k++) begin : g_div
		logic [VW+1:0] trial;
		logic          ge;
		logic [VW+1:0] diff;
		always_comb begin
			trial = {rem_d[k], lo_d[k][CW-1]};
			ge = trial >= {1'b0, ud_d[k]};
			diff = trial - {1'b0, ud_d[k]};
		end
		always_ff @(posedge clk) begin
			rem_d[k+1] <= ge ? diff[VW:0] : trial[VW:0];
			lo_d[k+1] <= {lo_d[k][CW-2:0], 1'b0};
			quo_d[k+1] <= {quo_d[k][CW-2:0], ge};
			ud_d[k+1] <= ud_d[k];
			c0_d[k+1] <= c0_d[k];
			skip_d[k+1] <= skip_d[k];
			dneg_d[k+1] <= dneg_d[k];
		end
	end

	always_comb begin
		cmax = (CW+2)'({1'b0, {(CW-1){1'b1}}});
		cmin = -cmax - (CW+2)'(1);
		if (dneg_d[CW])
			sum = (CW+2)'(signed'(c0_d[CW])) - (CW+2)'(quo_d[CW]);
		else
			sum = (CW+2)'(signed'(c0_d[CW])) + (CW+2)'(quo_d[CW]);
	end

	always_ff @(posedge clk) begin
		if (skip_d[CW])
			pt_q <= c0_d[CW];
		else if (sum > cmax)
			pt_q <= cmax[CW-1:0];
		else if (sum < cmin)
			pt_q <= cmin[CW-1:0];
		else
			pt_q <= sum[CW-1:0];
	end

	assign pt = signed'(pt_q);

endmodule

/* rtl/core/mtc_lane.sv */
// One triangle lane: undefined check, corner pattern, edge choice and two crossings.
// Uses mtc_interp for the four coordinates; the valid and hit flags follow in a matching shift register.
module mtc_lane import mtc_pkg::*; #(
	parameter int CW = 16,
	parameter int VW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [VW-1:0] level,
	input  logic signed [VW-1:0] undef,
	input  logic signed [CW-1:0] t0_a,
	input  logic signed [CW-1:0] t0_b,
	input  logic signed [VW-1:0] t0_w,
	input  logic signed [CW-1:0] t1_a,
	input  logic signed [CW-1:0] t1_b,
	input  logic signed [VW-1:0] t1_w,
	input  logic signed [CW-1:0] t2_a,
	input  logic signed [CW-1:0] t2_b,
	input  logic signed [VW-1:0] t2_w,
	output logic                 out_valid,
	output logic                 out_hit,
	output logic signed [CW-1:0] sa,
	output logic signed [CW-1:0] sb,
	output logic signed [CW-1:0] ea,
	output logic signed [CW-1:0] eb
);

	localparam int LAT = CW + 3;

	logic [2:0]            pat;
	logic                  hit;
	logic signed [CW-1:0]  x0q_a, x0q_b, x1p_a, x1p_b;
	logic signed [VW-1:0]  x0q_w, x1p_w;
	logic signed [VW:0]    num0, den0, num1, den1;
	logic                  vld_q [1:LAT];
	logic                  hit_q [1:LAT];

	always_comb begin
		pat = '0;
		if (t0_w >= level) pat = pat | PAT_C0;
		if (t1_w >= level) pat = pat | PAT_C1;
		if (t2_w >= level) pat = pat | PAT_C2;
		hit = (t0_w != undef) && (t1_w != undef) && (t2_w != undef) &&
			(pat != 3'd0) && (pat != 3'd7);
		// The first crossing always starts at the first corner.
		case (pat) inside
			3'd1, 3'd6: begin
				x0q_a = t2_a; x0q_b = t2_b; x0q_w = t2_w;
			end
			default: begin
				x0q_a = t1_a; x0q_b = t1_b; x0q_w = t1_w;
			end
		endcase
		// The second crossing always ends at the third corner.
		case (pat) inside
			3'd3, 3'd4: begin
				x1p_a = t0_a; x1p_b = t0_b; x1p_w = t0_w;
			end
			default: begin
				x1p_a = t1_a; x1p_b = t1_b; x1p_w = t1_w;
			end
		endcase
		num0 = (VW+1)'(level) - (VW+1)'(t0_w);
		den0 = (VW+1)'(x0q_w) - (VW+1)'(t0_w);
		num1 = (VW+1)'(level) - (VW+1)'(x1p_w);
		den1 = (VW+1)'(t2_w) - (VW+1)'(x1p_w);
	end

	mtc_interp #(.CW(CW), .VW(VW)) u_sa (.clk(clk), .c0(t0_a), .c1(x0q_a),
		.num(num0), .den(den0), .pt(sa));
	mtc_interp #(.CW(CW), .VW(VW)) u_sb (.clk(clk), .c0(t0_b), .c1(x0q_b),
		.num(num0), .den(den0), .pt(sb));
	mtc_interp #(.CW(CW), .VW(VW)) u_ea (.clk(clk), .c0(x1p_a), .c1(t2_a),
		.num(num1), .den(den1), .pt(ea));
	mtc_interp #(.CW(CW), .VW(VW)) u_eb (.clk(clk), .c0(x1p_b), .c1(t2_b),
		.num(num1), .den(den1), .pt(eb));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) begin
				vld_q[i] <= 1'b0;
				hit_q[i] <= 1'b0;
			end
		end else begin
			vld_q[1] <= in_valid;
			hit_q[1] <= hit;
			for (int i = 2; i <= LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
				hit_q[i] <= hit_q[i-1];
			end
		end
	end

	// A segment that collapses to a point is dropped.
	assign out_valid = vld_q[LAT];
	assign out_hit = hit_q[LAT] && !((sa == ea) && (sb == eb));

endmodule

/* rtl/core/marching_triangles_contour_cell.sv */
// Top level of the marching-triangles contour cell: registers, two triangle lanes, merge.
// Depends on mtc_pkg, mtc_lane and mtc_interp.
//
// Channel   Direction  Handshake                      Payload
// grid_cell in         start high while busy low      cell_t, one grid cell
// result    out        result_valid, one cycle only   seg_t, one segment
// config    in/out     APB, pready tied high          contour_level, undefined_value
//
// A cell is taken in one beat and then busy stays high for one cycle, so a start in
// that cycle is refused; this spacing is set by the single result channel, which
// must carry up to two segments per cell.
// A result passes one input register, the interpolator pipeline (operand register,
// one multiply stage, one divider stage per quotient bit, clip register) and the
// output register. The second segment of a cell follows in the next cycle.
// Reset clears the control flags and sets both registers to their defaults; the
// receiver cannot stall, so nothing ever waits on the output side.
module marching_triangles_contour_cell import mtc_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cell_t                grid_cell,
	output logic                 result_valid,
	output seg_t                 result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int CW = COORD_BITS;
	localparam int VW = VALUE_BITS;

	logic                  take;
	logic                  busy_q;
	logic [VW-1:0]         level_q;
	logic [VW-1:0]         undef_q;
	logic [REG_IDX_BITS-1:0] reg_idx;

	logic                  vld_s1;
	logic signed [CW-1:0]  a0_s1, a1_s1, b0_s1, b1_s1;
	logic signed [VW-1:0]  w00_s1, w01_s1, w11_s1, w10_s1;

	logic                  l0_valid, l0_hit, l1_valid, l1_hit;
	logic signed [CW-1:0]  l0_sa, l0_sb, l0_ea, l0_eb;
	logic signed [CW-1:0]  l1_sa, l1_sb, l1_ea, l1_eb;
	seg_t                  seg0, seg1;

	logic                  res_vld_q;
	seg_t                  res_q;
	logic                  pend_q;
	seg_t                  pend_seg_q;

	assign take = start && !busy_q;
	assign busy = busy_q;
	assign pready = 1'b1;
	assign reg_idx = paddr[ADDR_BITS-1:2];

	// Configuration registers, written by the user only while no cell is in flight; unchecked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			undef_q <= {1'b1, {(VW-1){1'b0}}};
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_LEVEL: level_q <= VW'(pwdata);
				REG_UNDEF: undef_q <= VW'(pwdata);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LEVEL: prdata = 32'(level_q);
			REG_UNDEF: prdata = 32'(undef_q);
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			busy_q <= take;
			vld_s1 <= take;
		end
	end

	// The fields are taken at the internal widths: narrower widths keep the low bits.
	always_ff @(posedge clk) begin
		if (take) begin
			a0_s1 <= CW'($unsigned(grid_cell.axis_a_low));
			a1_s1 <= CW'($unsigned(grid_cell.axis_a_high));
			b0_s1 <= CW'($unsigned(grid_cell.axis_b_low));
			b1_s1 <= CW'($unsigned(grid_cell.axis_b_high));
			w00_s1 <= VW'($unsigned(grid_cell.value_00));
			w01_s1 <= VW'($unsigned(grid_cell.value_01));
			w11_s1 <= VW'($unsigned(grid_cell.value_11));
			w10_s1 <= VW'($unsigned(grid_cell.value_10));
		end
	end

	// Lane 0 handles the triangle through c01, lane 1 the one through c10.
	mtc_lane #(.CW(CW), .VW(VW)) u_lane0 (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s1),
		.level(signed'(level_q)), .undef(signed'(undef_q)),
		.t0_a(a0_s1), .t0_b(b0_s1), .t0_w(w00_s1),
		.t1_a(a0_s1), .t1_b(b1_s1), .t1_w(w01_s1),
		.t2_a(a1_s1), .t2_b(b1_s1), .t2_w(w11_s1),
		.out_valid(l0_valid), .out_hit(l0_hit),
		.sa(l0_sa), .sb(l0_sb), .ea(l0_ea), .eb(l0_eb)
	);

	mtc_lane #(.CW(CW), .VW(VW)) u_lane1 (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s1),
		.level(signed'(level_q)), .undef(signed'(undef_q)),
		.t0_a(a0_s1), .t0_b(b0_s1), .t0_w(w00_s1),
		.t1_a(a1_s1), .t1_b(b0_s1), .t1_w(w10_s1),
		.t2_a(a1_s1), .t2_b(b1_s1), .t2_w(w11_s1),
		.out_valid(l1_valid), .out_hit(l1_hit),
		.sa(l1_sa), .sb(l1_sb), .ea(l1_ea), .eb(l1_eb)
	);

	// Merge: the first triangle goes first; a second segment is parked in pend_seg_q behind it.
	always_comb begin
		seg0.start_a = 16'($unsigned(l0_sa));
		seg0.start_b = 16'($unsigned(l0_sb));
		seg0.end_a = 16'($unsigned(l0_ea));
		seg0.end_b = 16'($unsigned(l0_eb));
		seg0.triangle_sel = 1'b0;
		seg0.last_segment = !l1_hit;
		seg1.start_a = 16'($unsigned(l1_sa));
		seg1.start_b = 16'($unsigned(l1_sb));
		seg1.end_a = 16'($unsigned(l1_ea));
		seg1.end_b = 16'($unsigned(l1_eb));
		seg1.triangle_sel = 1'b1;
		seg1.last_segment = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			res_vld_q <= 1'b0;
			pend_q <= 1'b0;
			if (l0_valid && l1_valid && l0_hit) begin
				res_vld_q <= 1'b1;
				pend_q <= l1_hit;
			end else if (l1_valid && l1_hit) begin
				res_vld_q <= 1'b1;
			end else if (pend_q) begin
				res_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (l0_valid && l0_hit)
			res_q <= seg0;
		else if (l1_valid && l1_hit)
			res_q <= seg1;
		else if (pend_q)
			res_q <= pend_seg_q;
		if (l1_valid)
			pend_seg_q <= seg1;
	end

	assign result_valid = res_vld_q;
	assign result = res_q;

endmodule
